>>> rtl/core/fbfl_pkg.sv
// Shared widths, codes, reset values and state encoding of the block pool allocator.
package fbfl_pkg;

	localparam int IDX_W      = 10;
	localparam int OFF_W      = 26;
	localparam int CMD_W      = 3;
	localparam int STAT_W     = 2;
	localparam int LEN_W      = 17;
	localparam int CNT_W      = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 17;
	localparam int DIV_CNT_W  = 5;
	localparam int INDEX_SPAN = 1024;

	localparam int MAX_BLOCKS_DEF = 1024;

	localparam logic [CMD_W-1:0] CMD_INIT           = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ALLOC          = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FREE           = 3'd2;
	localparam logic [CMD_W-1:0] CMD_OFFSET_OF_NODE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_NODE_OF_OFFSET = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOT_INIT = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT  = 1'd1;

	localparam logic [LEN_W-1:0] BLOCK_LENGTH_RST = 17'd64;
	localparam logic [CNT_W-1:0] BLOCK_COUNT_RST  = 11'd1024;

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_INIT     = 6'b000010,
		S_ALLOC_RD = 6'b000100,
		S_FREE2    = 6'b001000,
		S_DIV      = 6'b010000,
		S_RESULT   = 6'b100000
	} state_t;

endpackage

>>> rtl/core/fbfl_req_if.sv
// Request channel of the block pool allocator.
interface fbfl_req_if;
	logic                         valid;
	logic                         ready;
	logic [fbfl_pkg::CMD_W-1:0]   command;
	logic [fbfl_pkg::IDX_W-1:0]   node_index;
	logic [fbfl_pkg::OFF_W-1:0]   byte_offset;

	modport source (output valid, command, node_index, byte_offset, input ready);
	modport sink (input valid, command, node_index, byte_offset, output ready);
endinterface

>>> rtl/core/fbfl_rsp_if.sv
// Response channel of the block pool allocator.
interface fbfl_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [fbfl_pkg::STAT_W-1:0]   status;
	logic [fbfl_pkg::IDX_W-1:0]    result_index;
	logic [fbfl_pkg::OFF_W-1:0]    result_offset;

	modport source (output valid, status, result_index, result_offset, input ready);
	modport sink (input valid, status, result_index, result_offset, output ready);
endinterface

>>> rtl/core/fbfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fbfl_ram #(
	parameter int WIDTH = fbfl_pkg::IDX_W,
	parameter int DEPTH = fbfl_pkg::INDEX_SPAN
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/core/fixed_block_free_list_allocator_unit.sv
// Fixed-size block pool allocator: FIFO free list in a link RAM, with offset and index mapping.
// One request is in work at a time. A finished response waits in the output register while the
// next request is taken; a second finished response holds the input until the sink takes the
// first. Offset of node goes straight from idle to the result state. Free writes the link of the
// freed node, and makes a second link-RAM write when it appends behind a tail. Alloc reads the
// link of the head. Node of offset runs a restoring divider that yields one quotient bit per
// cycle. A refused request (not initialized, out of range, empty pool, zero block length,
// unknown command) goes straight from idle to the result state. Init writes one link per cycle.
// The link RAM holds min(MAX_BLOCKS, 1024) entries and is never cleared; init builds the list
// before any entry is read.
module fixed_block_free_list_allocator_unit #(
	parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbfl_pkg::CFG_DATA_W-1:0] cfg_wdata,
	fbfl_req_if.sink                        req,
	fbfl_rsp_if.source                      rsp
);
	import fbfl_pkg::*;

	localparam int DEPTH = (MAX_BLOCKS < INDEX_SPAN) ? MAX_BLOCKS : INDEX_SPAN;
	localparam int AW = $clog2(DEPTH);
	localparam logic [CNT_W-1:0] CAP = CNT_W'(DEPTH);

	state_t state_q;

	logic [LEN_W-1:0]     length_q;
	logic [CNT_W-1:0]     count_cfg_q;
	logic [CNT_W-1:0]     count_eff;

	logic [IDX_W-1:0]     head_q;
	logic [IDX_W-1:0]     tail_q;
	logic                 empty_q;
	logic                 init_done_q;

	logic [IDX_W-1:0]     nidx_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     init_i_q;
	logic [OFF_W-1:0]     qr_q;
	logic [LEN_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [STAT_W-1:0]    status_q;
	logic                 is_div_q;

	logic                 out_valid_q;
	logic [STAT_W-1:0]    out_status_q;
	logic [IDX_W-1:0]     out_index_q;
	logic [OFF_W-1:0]     out_offset_q;

	logic                 nidx_ok;
	logic                 init_last;
	logic [CNT_W-1:0]     init_next;
	logic                 res_load;
	logic [LEN_W:0]       trial;
	logic                 div_ge;
	logic [LEN_W-1:0]     rem_nxt;
	logic [STAT_W-1:0]    st_final;
	logic [OFF_W:0]       prod;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [IDX_W-1:0]     ram_wdata;
	logic [IDX_W-1:0]     ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q    <= BLOCK_LENGTH_RST;
			count_cfg_q <= BLOCK_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLOCK_LENGTH: length_q    <= cfg_wdata[LEN_W-1:0];
				REG_BLOCK_COUNT:  count_cfg_q <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign count_eff = (count_cfg_q > CAP) ? CAP : count_cfg_q;
	assign nidx_ok   = {1'b0, req.node_index} < count_eff;
	assign init_next = init_i_q + CNT_W'(1);
	assign init_last = init_next == count_q;
	assign res_load  = (state_q == S_RESULT) && (!out_valid_q || rsp.ready);

	assign trial   = {rem_q, qr_q[OFF_W-1]};
	assign div_ge  = trial >= {1'b0, length_q};
	assign rem_nxt = div_ge ? LEN_W'(trial - {1'b0, length_q}) : trial[LEN_W-1:0];

	assign st_final = (is_div_q && (status_q == ST_OK) && (qr_q >= OFF_W'(count_q)))
		? ST_RANGE : status_q;
	assign prod = (OFF_W+1)'(qr_q[IDX_W-1:0]) * (OFF_W+1)'(length_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		case (state_q)
			S_IDLE: begin
				if (req.valid && (req.command == CMD_FREE) && init_done_q && nidx_ok) begin
					ram_we    = 1'b1;
					ram_waddr = req.node_index[AW-1:0];
				end
			end
			S_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = init_i_q[AW-1:0];
				ram_wdata = init_last ? '0 : init_next[IDX_W-1:0];
			end
			S_FREE2: begin
				ram_we    = 1'b1;
				ram_waddr = tail_q[AW-1:0];
				ram_wdata = nidx_q;
			end
			default: ;
		endcase
	end

	fbfl_ram #(
		.WIDTH (IDX_W),
		.DEPTH (DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (head_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			empty_q     <= 1'b1;
			init_done_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						case (req.command)
							CMD_INIT: begin
								if (count_eff == '0) begin
									head_q      <= '0;
									tail_q      <= '0;
									empty_q     <= 1'b1;
									init_done_q <= 1'b1;
									state_q     <= S_RESULT;
								end else begin
									state_q <= S_INIT;
								end
							end
							CMD_ALLOC: begin
								state_q <= (init_done_q && !empty_q) ? S_ALLOC_RD : S_RESULT;
							end
							CMD_FREE: begin
								if (init_done_q && nidx_ok) begin
									if (empty_q) begin
										head_q  <= req.node_index;
										tail_q  <= req.node_index;
										empty_q <= 1'b0;
										state_q <= S_RESULT;
									end else begin
										state_q <= S_FREE2;
									end
								end else begin
									state_q <= S_RESULT;
								end
							end
							CMD_NODE_OF_OFFSET: begin
								state_q <= (init_done_q && (length_q != '0)) ? S_DIV : S_RESULT;
							end
							default: state_q <= S_RESULT;
						endcase
					end
				end
				S_INIT: begin
					if (init_last) begin
						head_q      <= '0;
						tail_q      <= init_i_q[IDX_W-1:0];
						empty_q     <= 1'b0;
						init_done_q <= 1'b1;
						state_q     <= S_RESULT;
					end
				end
				S_ALLOC_RD: begin
					if (head_q == tail_q) begin
						empty_q <= 1'b1;
						head_q  <= '0;
						tail_q  <= '0;
					end else begin
						head_q <= ram_rdata;
					end
					state_q <= S_RESULT;
				end
				S_FREE2: begin
					tail_q  <= nidx_q;
					state_q <= S_RESULT;
				end
				S_DIV: begin
					if (div_cnt_q == '0) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					nidx_q    <= req.node_index;
					count_q   <= count_eff;
					init_i_q  <= '0;
					rem_q     <= '0;
					div_cnt_q <= DIV_CNT_W'(OFF_W - 1);
					is_div_q  <= req.command == CMD_NODE_OF_OFFSET;
					case (req.command)
						CMD_INIT: begin
							qr_q     <= '0;
							status_q <= ST_OK;
						end
						CMD_ALLOC: begin
							qr_q     <= OFF_W'(head_q);
							status_q <= !init_done_q ? ST_NOT_INIT
								: (empty_q ? ST_EMPTY : ST_OK);
						end
						CMD_FREE, CMD_OFFSET_OF_NODE: begin
							qr_q     <= OFF_W'(req.node_index);
							status_q <= !init_done_q ? ST_NOT_INIT
								: (!nidx_ok ? ST_RANGE : ST_OK);
						end
						CMD_NODE_OF_OFFSET: begin
							qr_q     <= req.byte_offset;
							status_q <= !init_done_q ? ST_NOT_INIT
								: ((length_q == '0) ? ST_RANGE : ST_OK);
						end
						default: begin
							qr_q     <= '0;
							status_q <= ST_RANGE;
						end
					endcase
				end
			end
			S_INIT: init_i_q <= init_next;
			S_DIV: begin
				rem_q     <= rem_nxt;
				qr_q      <= {qr_q[OFF_W-2:0], div_ge};
				div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
			end
			S_RESULT: begin
				if (res_load) begin
					out_status_q <= st_final;
					out_index_q  <= (st_final == ST_OK) ? qr_q[IDX_W-1:0] : '0;
					out_offset_q <= (st_final == ST_OK) ? prod[OFF_W-1:0] : '0;
				end
			end
			default: ;
		endcase
	end

	assign req.ready         = state_q == S_IDLE;
	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.result_index  = out_index_q;
	assign rsp.result_offset = out_offset_q;

	a_empty_pointers_zero: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (head_q == '0) && (tail_q == '0))
		else $error("empty list with nonzero head or tail");

	a_uninit_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!init_done_q |-> empty_q)
		else $error("list holds blocks before init");

	a_init_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INIT) |-> (init_i_q < count_q))
		else $error("init walk past block count");

	a_append_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FREE2) |-> !empty_q)
		else $error("tail append on empty list");

endmodule
